### design/gillespie_predator_prey_step_assert.svh
// Assertion macros used by the port-level checker.
`ifndef GILLESPIE_PREDATOR_PREY_STEP_ASSERT_SVH
`define GILLESPIE_PREDATOR_PREY_STEP_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GPPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gpps assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define GPPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gpps assertion failed");

`endif

### design/gpps_pkg.sv
// Shared constants, types and tables of the predator-prey step engine.
package gpps_pkg;

  localparam int CNT_W      = 12;
  localparam int RATE_W     = 24;
  localparam int TIME_W     = 48;
  localparam int DRAW_W     = 16;
  localparam int KIND_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TERM_W     = 52;
  localparam int ALU_W      = 72;
  localparam int DIV_BITS   = 56;
  localparam int DIV_CNT_W  = $clog2(DIV_BITS);
  localparam int LOG_W      = 21;
  localparam logic [DRAW_W:0] LN2_Q16   = 17'd45426;
  localparam logic [TIME_W-1:0] UNIT_TIME = TIME_W'(65536);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SITE_COUNT  = 3'd0,
    CFG_PRED_DEATH  = 3'd1,
    CFG_PREY_BIRTH  = 3'd2,
    CFG_PRED_BREED  = 3'd3,
    CFG_PRED_PLAIN  = 3'd4,
    CFG_PREY_DEATH  = 3'd5,
    CFG_TIME_MODE   = 3'd6
  } cfg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_RESTART    = 3'd0,
    KIND_PRED_DEATH = 3'd1,
    KIND_PREY_BIRTH = 3'd2,
    KIND_PREY_LOSS  = 3'd3,
    KIND_PREDATION  = 3'd4,
    KIND_ABSORBED   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    STEP_T1,
    STEP_NM,
    STEP_ME,
    STEP_BME,
    STEP_T2,
    STEP_PNM,
    STEP_P2,
    STEP_BNM,
    STEP_T4,
    STEP_DM,
    STEP_R,
    STEP_LOG,
    STEP_X,
    STEP_DT
  } step_e;

  typedef struct packed {
    logic             start;
    logic             is_div;
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ALU_W-1:0] result;
  } alu_rsp_t;

  function automatic logic [DRAW_W:0] log2_tab(input logic [4:0] idx);
    logic [DRAW_W:0] v;
    case (idx)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      5'd16:   v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

### design/gillespie_predator_prey_step.sv
// Top level of the Gillespie predator-prey step engine.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+------------------------------------------
//   in      | in_valid_i / in_ready_o     | op_i, event_draw_i, time_draw_i
//   out     | out_valid_o / out_ready_i   | predator_count_o, prey_count_o,
//           |                             | elapsed_time_o, event_kind_o, absorbed_o
//   cfg     | cfg_we_i                    | cfg_index_i, cfg_data_i
//
// A step transaction runs ten multiplies and four divides in turn on the one
// shared unit; unit time mode skips the log and the last divide. The block takes
// one transaction at a time and is ready again once the result sits in the output
// register. A stalled output holds the commit of the next result. Reset loads
// the default configuration and a full lattice, half predators and half prey.
module gillespie_predator_prey_step (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [gpps_pkg::DRAW_W-1:0]       event_draw_i,
  input  logic [gpps_pkg::DRAW_W-1:0]       time_draw_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [gpps_pkg::CNT_W-1:0]        predator_count_o,
  output logic [gpps_pkg::CNT_W-1:0]        prey_count_o,
  output logic [gpps_pkg::TIME_W-1:0]       elapsed_time_o,
  output logic [gpps_pkg::KIND_W-1:0]       event_kind_o,
  output logic                              absorbed_o,
  input  logic                              cfg_we_i,
  input  logic [gpps_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gpps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  localparam int CW = gpps_pkg::CNT_W;
  localparam int RW = gpps_pkg::RATE_W;
  localparam int TW = gpps_pkg::TERM_W;
  localparam int AW = gpps_pkg::ALU_W;
  localparam int HW = gpps_pkg::TIME_W;
  localparam int DW = gpps_pkg::DRAW_W;
  localparam int LW = gpps_pkg::LOG_W;

  logic [CW-1:0] site_q;
  logic [RW-1:0] d1_q, b_q, p1_q, p2_q, d2_q;
  logic          tmode_q;

  logic [CW-1:0] pred_q, pred_d, prey_q, prey_d;
  logic [HW-1:0] time_q, time_d;
  logic [gpps_pkg::KIND_W-1:0] kind_q, kind_d;
  logic          abs_out_q, abs_out_d;
  logic          out_valid_q, out_valid_d;

  gpps_pkg::state_e st_q, st_d;
  gpps_pkg::step_e  step_q, step_d;
  logic          issued_q, issued_d;
  logic          op_q;
  logic [DW-1:0] u1_q, u2_q;
  logic          abs_q, abs_d;

  logic [TW-1:0] t1_q, t1_d, t2_q, t2_d, t3_q, t3_d, t4_q, t4_d;
  logic [TW-1:0] tmp_q, tmp_d, lam_q, lam_d, r_q, r_d;
  logic [2*CW-1:0] nm_q, nm_d, me_q, me_d;
  logic [LW-1:0] g_q, g_d;
  logic [HW-1:0] dt_q, dt_d;

  gpps_pkg::alu_req_t alu_req;
  gpps_pkg::alu_rsp_t alu_rsp;

  logic [CW:0]   occ;
  logic [CW-1:0] empty;
  logic [TW-1:0] lam_sum, c2, c3;
  logic [DW:0]   w, w_sh, ta, tb;
  logic [4:0]    k;
  logic [3:0]    idx;
  logic [11:0]   lo;
  logic [LW-1:0] logv;
  logic [HW:0]   time_sum;
  logic          accept;

  gpps_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      site_q  <= CW'(1024);
      d1_q    <= RW'(65536);
      b_q     <= RW'(65536);
      p1_q    <= RW'(65536);
      p2_q    <= RW'(65536);
      d2_q    <= RW'(65536);
      tmode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (gpps_pkg::cfg_idx_e'(cfg_index_i))
        gpps_pkg::CFG_SITE_COUNT: site_q  <= cfg_data_i[CW-1:0];
        gpps_pkg::CFG_PRED_DEATH: d1_q    <= cfg_data_i[RW-1:0];
        gpps_pkg::CFG_PREY_BIRTH: b_q     <= cfg_data_i[RW-1:0];
        gpps_pkg::CFG_PRED_BREED: p1_q    <= cfg_data_i[RW-1:0];
        gpps_pkg::CFG_PRED_PLAIN: p2_q    <= cfg_data_i[RW-1:0];
        gpps_pkg::CFG_PREY_DEATH: d2_q    <= cfg_data_i[RW-1:0];
        gpps_pkg::CFG_TIME_MODE:  tmode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign occ     = {1'b0, pred_q} + {1'b0, prey_q};
  assign empty   = ({1'b0, site_q} > occ) ? CW'({1'b0, site_q} - occ) : '0;
  assign lam_sum = t1_q + t2_q + t3_q + t4_q;
  assign c2      = t1_q + t2_q;
  assign c3      = c2 + t3_q;

  always_comb begin
    k = '0;
    for (int i = 0; i <= DW; i++) begin
      if (w[i]) k = 5'(i);
    end
  end
  assign w    = (DW+1)'(1 << DW) - {1'b0, u2_q};
  assign w_sh = w << (5'(DW) - k);
  assign idx  = w_sh[DW-1:DW-4];
  assign lo   = w_sh[11:0];
  assign ta   = gpps_pkg::log2_tab({1'b0, idx});
  assign tb   = gpps_pkg::log2_tab(5'({1'b0, idx}) + 5'd1);
  assign logv = {k, 16'b0} + LW'(ta) + LW'(alu_rsp.result[24:12]);

  assign accept    = in_valid_i && in_ready_o;
  assign time_sum  = {1'b0, time_q} + {1'b0, dt_q};

  always_comb begin
    alu_req.start  = (st_q == gpps_pkg::ST_CALC) && !issued_q && !alu_rsp.busy;
    alu_req.is_div = 1'b0;
    alu_req.a      = '0;
    alu_req.b      = '0;
    case (step_q)
      gpps_pkg::STEP_T1:  begin alu_req.a = AW'(d1_q);   alu_req.b = AW'(pred_q); end
      gpps_pkg::STEP_NM:  begin alu_req.a = AW'(pred_q); alu_req.b = AW'(prey_q); end
      gpps_pkg::STEP_ME:  begin alu_req.a = AW'(prey_q); alu_req.b = AW'(empty);  end
      gpps_pkg::STEP_BME: begin alu_req.a = AW'(b_q);    alu_req.b = AW'(me_q);   end
      gpps_pkg::STEP_PNM: begin alu_req.a = AW'(p2_q);   alu_req.b = AW'(nm_q);   end
      gpps_pkg::STEP_BNM: begin alu_req.a = AW'(p1_q);   alu_req.b = AW'(nm_q);   end
      gpps_pkg::STEP_DM:  begin alu_req.a = AW'(d2_q);   alu_req.b = AW'(prey_q); end
      gpps_pkg::STEP_R:   begin alu_req.a = AW'(lam_sum); alu_req.b = AW'(u1_q);  end
      gpps_pkg::STEP_LOG: begin alu_req.a = AW'(tb - ta); alu_req.b = AW'(lo);    end
      gpps_pkg::STEP_X:   begin alu_req.a = AW'(g_q); alu_req.b = AW'(gpps_pkg::LN2_Q16); end
      gpps_pkg::STEP_DT:  begin
        alu_req.is_div = 1'b1;
        alu_req.a      = AW'(tmp_q);
        alu_req.b      = AW'(lam_q);
      end
      gpps_pkg::STEP_T2, gpps_pkg::STEP_P2, gpps_pkg::STEP_T4: begin
        alu_req.is_div = 1'b1;
        alu_req.a      = AW'({tmp_q, 1'b0});
        alu_req.b      = AW'(site_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    st_d        = st_q;
    step_d      = step_q;
    issued_d    = issued_q;
    abs_d       = abs_q;
    t1_d = t1_q; t2_d = t2_q; t3_d = t3_q; t4_d = t4_q;
    tmp_d = tmp_q; lam_d = lam_q; r_d = r_q;
    nm_d = nm_q; me_d = me_q; g_d = g_q; dt_d = dt_q;
    pred_d      = pred_q;
    prey_d      = prey_q;
    time_d      = time_q;
    kind_d      = kind_q;
    abs_out_d   = abs_out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = (st_q == gpps_pkg::ST_IDLE);
    case (st_q)
      gpps_pkg::ST_IDLE: begin
        if (accept) begin
          abs_d    = 1'b0;
          issued_d = 1'b0;
          step_d   = gpps_pkg::STEP_T1;
          st_d     = op_i ? gpps_pkg::ST_CALC : gpps_pkg::ST_DONE;
        end
      end
      gpps_pkg::ST_CALC: begin
        if (alu_req.start) issued_d = 1'b1;
        if (alu_rsp.done) begin
          issued_d = 1'b0;
          step_d   = gpps_pkg::step_e'(step_q + 1'b1);
          case (step_q)
            gpps_pkg::STEP_T1:  t1_d  = TW'(alu_rsp.result);
            gpps_pkg::STEP_NM:  nm_d  = (2*CW)'(alu_rsp.result);
            gpps_pkg::STEP_ME:  me_d  = (2*CW)'(alu_rsp.result);
            gpps_pkg::STEP_BME: tmp_d = TW'(alu_rsp.result);
            gpps_pkg::STEP_T2:  t2_d  = (site_q == '0) ? '0 : TW'(alu_rsp.result);
            gpps_pkg::STEP_PNM: tmp_d = TW'(alu_rsp.result);
            gpps_pkg::STEP_P2:  t3_d  = (site_q == '0) ? '0 : TW'(alu_rsp.result);
            gpps_pkg::STEP_BNM: tmp_d = TW'(alu_rsp.result);
            gpps_pkg::STEP_T4:  t4_d  = (site_q == '0) ? '0 : TW'(alu_rsp.result);
            gpps_pkg::STEP_DM:  t3_d  = t3_q + TW'(alu_rsp.result);
            gpps_pkg::STEP_R: begin
              r_d   = TW'(alu_rsp.result >> 16);
              lam_d = lam_sum;
              if (lam_sum == '0) begin
                abs_d = 1'b1;
                st_d  = gpps_pkg::ST_DONE;
              end else if (tmode_q) begin
                dt_d = gpps_pkg::UNIT_TIME;
                st_d = gpps_pkg::ST_DONE;
              end
            end
            gpps_pkg::STEP_LOG: g_d   = LW'(1 << 20) - logv;
            gpps_pkg::STEP_X:   tmp_d = TW'(alu_rsp.result);
            gpps_pkg::STEP_DT: begin
              dt_d = HW'(alu_rsp.result);
              st_d = gpps_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
      end
      gpps_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          st_d        = gpps_pkg::ST_IDLE;
          abs_out_d   = 1'b0;
          if (!op_q) begin
            pred_d = site_q >> 1;
            prey_d = site_q >> 1;
            time_d = '0;
            kind_d = gpps_pkg::KIND_RESTART;
          end else if (abs_q) begin
            kind_d    = gpps_pkg::KIND_ABSORBED;
            abs_out_d = 1'b1;
          end else begin
            time_d = time_sum[HW] ? '1 : time_sum[HW-1:0];
            if (r_q < t1_q) begin
              kind_d = gpps_pkg::KIND_PRED_DEATH;
              if (pred_q != '0) pred_d = pred_q - 1'b1;
            end else if (r_q < c2) begin
              kind_d = gpps_pkg::KIND_PREY_BIRTH;
              if (prey_q != '1) prey_d = prey_q + 1'b1;
            end else if (r_q < c3) begin
              kind_d = gpps_pkg::KIND_PREY_LOSS;
              if (prey_q != '0) prey_d = prey_q - 1'b1;
            end else begin
              kind_d = gpps_pkg::KIND_PREDATION;
              if (pred_q != '1) pred_d = pred_q + 1'b1;
              if (prey_q != '0) prey_d = prey_q - 1'b1;
            end
          end
        end
      end
      default: st_d = gpps_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= gpps_pkg::ST_IDLE;
      step_q      <= gpps_pkg::STEP_T1;
      issued_q    <= 1'b0;
      abs_q       <= 1'b0;
      out_valid_q <= 1'b0;
      pred_q      <= CW'(512);
      prey_q      <= CW'(512);
      time_q      <= '0;
      kind_q      <= gpps_pkg::KIND_RESTART;
      abs_out_q   <= 1'b0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      issued_q    <= issued_d;
      abs_q       <= abs_d;
      out_valid_q <= out_valid_d;
      pred_q      <= pred_d;
      prey_q      <= prey_d;
      time_q      <= time_d;
      kind_q      <= kind_d;
      abs_out_q   <= abs_out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= op_i;
      u1_q <= event_draw_i;
      u2_q <= time_draw_i;
    end
    t1_q  <= t1_d;
    t2_q  <= t2_d;
    t3_q  <= t3_d;
    t4_q  <= t4_d;
    tmp_q <= tmp_d;
    lam_q <= lam_d;
    r_q   <= r_d;
    nm_q  <= nm_d;
    me_q  <= me_d;
    g_q   <= g_d;
    dt_q  <= dt_d;
  end

  assign out_valid_o      = out_valid_q;
  assign predator_count_o = pred_q;
  assign prey_count_o     = prey_q;
  assign elapsed_time_o   = time_q;
  assign event_kind_o     = kind_q;
  assign absorbed_o       = abs_out_q;

endmodule

### design/gpps_alu.sv
// Shared multiply (8 bits per cycle) and restoring divide (1 bit per cycle) unit.
module gpps_alu (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gpps_pkg::alu_req_t  req_i,
  output gpps_pkg::alu_rsp_t  rsp_o
);

  logic                                busy_q, busy_d;
  logic                                div_q, div_d;
  logic                                done_q, done_d;
  logic [gpps_pkg::ALU_W-1:0]          a_q, a_d, b_q, b_d, acc_q, acc_d, rem_q, rem_d;
  logic [gpps_pkg::ALU_W-1:0]          rem_sh;
  logic [gpps_pkg::DIV_CNT_W-1:0]      cnt_q, cnt_d;

  always_comb begin
    busy_d = busy_q;
    div_d  = div_q;
    done_d = 1'b0;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    rem_sh = {rem_q[gpps_pkg::ALU_W-2:0], a_q[gpps_pkg::DIV_BITS-1]};
    if (!busy_q) begin
      if (req_i.start) begin
        busy_d = 1'b1;
        div_d  = req_i.is_div;
        a_d    = req_i.a;
        b_d    = req_i.b;
        acc_d  = '0;
        rem_d  = '0;
        cnt_d  = gpps_pkg::DIV_CNT_W'(gpps_pkg::DIV_BITS - 1);
      end
    end else if (div_q) begin
      a_d = a_q << 1;
      if (rem_sh >= b_q) begin
        rem_d = rem_sh - b_q;
        acc_d = {acc_q[gpps_pkg::ALU_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        acc_d = {acc_q[gpps_pkg::ALU_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end else begin
      acc_d = acc_q + (a_q * gpps_pkg::ALU_W'(b_q[7:0]));
      a_d   = a_q << 8;
      b_d   = b_q >> 8;
      if (b_q[gpps_pkg::ALU_W-1:8] == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      div_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      div_q  <= div_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rem_q <= rem_d;
  end

  assign rsp_o.busy   = busy_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = acc_q;

endmodule

### design/gpps_checker.sv
// Port-level checker of the predator-prey step engine and its bind.
`include "gillespie_predator_prey_step_assert.svh"

module gpps_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [gpps_pkg::CNT_W-1:0]        predator_count_o,
  input logic [gpps_pkg::CNT_W-1:0]        prey_count_o,
  input logic [gpps_pkg::TIME_W-1:0]       elapsed_time_o,
  input logic [gpps_pkg::KIND_W-1:0]       event_kind_o,
  input logic                              absorbed_o
);

  localparam int PW = 2 * gpps_pkg::CNT_W + gpps_pkg::TIME_W + gpps_pkg::KIND_W + 1;

  logic          in_fire;
  logic          out_stall;
  logic          out_absorbed;
  logic          out_restart;
  logic          restart_ok;
  logic [PW-1:0] out_payload;

  assign in_fire      = in_valid_i && in_ready_o;
  assign out_stall    = out_valid_o && !out_ready_i;
  assign out_absorbed = out_valid_o && absorbed_o;
  assign out_restart  = out_valid_o && (event_kind_o == gpps_pkg::KIND_RESTART);
  assign restart_ok   = (elapsed_time_o == '0) && !absorbed_o;
  assign out_payload  = {predator_count_o, prey_count_o, elapsed_time_o, event_kind_o,
                         absorbed_o};

  `GPPS_ASSERT_NXT(busy_after_accept, in_fire, !in_ready_o)
  `GPPS_ASSERT_IMP(absorbed_kind, out_absorbed, event_kind_o == gpps_pkg::KIND_ABSORBED)
  `GPPS_ASSERT_IMP(restart_zero_time, out_restart, restart_ok)
  `GPPS_ASSERT_NXT(out_hold, out_stall, out_valid_o && $stable(out_payload))

endmodule

bind gillespie_predator_prey_step gpps_checker u_gpps_checker (.*);
